### src/ppd_pkg.sv
// Package: shared types and constants for the polyline point distance block.
`default_nettype none
package ppd_pkg;

	// Field widths
	localparam int CO_W  = 24;   // coordinate, Q.8 signed
	localparam int PT_W  = 25;   // stored point plus offset
	localparam int DF_W  = 26;   // coordinate difference
	localparam int DSQ_W = 54;   // squared distance, Q.16
	localparam int RT_W  = 27;   // root of a squared distance
	localparam int DS_W  = 25;   // distance output width

	// Request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// Path status codes
	localparam logic [1:0] STAT_NORMAL = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_SINGLE = 2'd2;

	localparam logic [DS_W-1:0] DIST_MAX = {DS_W{1'b1}};

	typedef struct packed {
		logic [1:0]             req_type;
		logic signed [CO_W-1:0] coord_x;
		logic signed [CO_W-1:0] coord_y;
	} ppd_in_t;

	typedef struct packed {
		logic [DS_W-1:0] distance;
		logic [1:0]      path_status;
	} ppd_out_t;

endpackage
`default_nettype wire

### src/ppd_mem.sv
// Point store: one write port, one synchronous read port.
`default_nettype none
module ppd_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int W     = 48
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [W-1:0]  rd_data
);

	logic [W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### src/ppd_seg.sv
// Segment unit: squared distance from a position to one segment.
`default_nettype none
module ppd_seg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [ppd_pkg::CO_W-1:0] qx,
	input  wire logic signed [ppd_pkg::CO_W-1:0] qy,
	input  wire logic signed [ppd_pkg::PT_W-1:0] p1x,
	input  wire logic signed [ppd_pkg::PT_W-1:0] p1y,
	input  wire logic signed [ppd_pkg::PT_W-1:0] p2x,
	input  wire logic signed [ppd_pkg::PT_W-1:0] p2y,
	output logic                               done,
	output logic [ppd_pkg::DSQ_W-1:0]          dsq
);
	import ppd_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DIFF, S_MUL, S_DEC, S_DIV} phase_t;

	localparam int SQ_W = 2 * DSQ_W - 2;   // 106-bit square of the cross product
	localparam int QW   = DSQ_W - 1;       // quotient bits
	localparam logic [3:0] ST_LAST = 4'd14;
	localparam logic [5:0] DIV_LAST = 6'(QW - 1);

	phase_t phase_q;
	logic [3:0] st_q;
	logic [5:0] cnt_q;

	logic signed [DF_W-1:0] ax_q, ay_q, cx_q, cy_q, bx_q, by_q;
	logic signed [DSQ_W-1:0] dot_q, len_q, da_q, db_q, cross_q;
	logic signed [55:0] prod_q;
	logic [SQ_W-1:0] sq_q;
	logic [QW-1:0] rem_q, lo_q, quo_q;

	logic signed [27:0] mul_a, mul_b;
	logic signed [55:0] prod;
	logic signed [DSQ_W-1:0] cross_abs, pe;
	logic [QW-1:0] m;
	logic [DSQ_W-1:0] r2, r2_sub;

	// Magnitude of the cross product, split into halves for squaring
	assign cross_abs = cross_q[DSQ_W-1] ? -cross_q : cross_q;
	assign m = cross_abs[QW-1:0];

	// Shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			4'd0:  begin mul_a = {{2{ax_q[DF_W-1]}}, ax_q}; mul_b = {{2{cx_q[DF_W-1]}}, cx_q}; end
			4'd1:  begin mul_a = {{2{ay_q[DF_W-1]}}, ay_q}; mul_b = {{2{cy_q[DF_W-1]}}, cy_q}; end
			4'd2:  begin mul_a = {{2{cx_q[DF_W-1]}}, cx_q}; mul_b = {{2{cx_q[DF_W-1]}}, cx_q}; end
			4'd3:  begin mul_a = {{2{cy_q[DF_W-1]}}, cy_q}; mul_b = {{2{cy_q[DF_W-1]}}, cy_q}; end
			4'd4:  begin mul_a = {{2{ax_q[DF_W-1]}}, ax_q}; mul_b = {{2{ax_q[DF_W-1]}}, ax_q}; end
			4'd5:  begin mul_a = {{2{ay_q[DF_W-1]}}, ay_q}; mul_b = {{2{ay_q[DF_W-1]}}, ay_q}; end
			4'd6:  begin mul_a = {{2{bx_q[DF_W-1]}}, bx_q}; mul_b = {{2{bx_q[DF_W-1]}}, bx_q}; end
			4'd7:  begin mul_a = {{2{by_q[DF_W-1]}}, by_q}; mul_b = {{2{by_q[DF_W-1]}}, by_q}; end
			4'd8:  begin mul_a = {{2{ax_q[DF_W-1]}}, ax_q}; mul_b = {{2{cy_q[DF_W-1]}}, cy_q}; end
			4'd9:  begin mul_a = {{2{ay_q[DF_W-1]}}, ay_q}; mul_b = {{2{cx_q[DF_W-1]}}, cx_q}; end
			4'd11: begin mul_a = {1'b0, m[26:0]}; mul_b = {1'b0, m[26:0]}; end
			4'd12: begin mul_a = {1'b0, m[26:0]}; mul_b = {2'b00, m[QW-1:27]}; end
			4'd13: begin mul_a = {2'b00, m[QW-1:27]}; mul_b = {2'b00, m[QW-1:27]}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign pe = prod_q[DSQ_W-1:0];

	// One restoring division step
	assign r2 = {rem_q, lo_q[QW-1]};
	assign r2_sub = r2 - len_q;

	// Sequencer, accumulators and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= S_IDLE;
			st_q    <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (phase_q)
				S_IDLE: begin
					if (start) begin
						phase_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					ax_q <= {{2{qx[CO_W-1]}}, qx} - {p1x[PT_W-1], p1x};
					ay_q <= {{2{qy[CO_W-1]}}, qy} - {p1y[PT_W-1], p1y};
					cx_q <= {p2x[PT_W-1], p2x} - {p1x[PT_W-1], p1x};
					cy_q <= {p2y[PT_W-1], p2y} - {p1y[PT_W-1], p1y};
					bx_q <= {{2{qx[CO_W-1]}}, qx} - {p2x[PT_W-1], p2x};
					by_q <= {{2{qy[CO_W-1]}}, qy} - {p2y[PT_W-1], p2y};
					st_q <= '0;
					phase_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= prod;
					case (st_q)
						4'd1:  dot_q   <= pe;
						4'd2:  dot_q   <= dot_q + pe;
						4'd3:  len_q   <= pe;
						4'd4:  len_q   <= len_q + pe;
						4'd5:  da_q    <= pe;
						4'd6:  da_q    <= da_q + pe;
						4'd7:  db_q    <= pe;
						4'd8:  db_q    <= db_q + pe;
						4'd9:  cross_q <= pe;
						4'd10: cross_q <= cross_q - pe;
						4'd12: sq_q    <= {{(SQ_W-DSQ_W){1'b0}}, prod_q[DSQ_W-1:0]};
						4'd13: sq_q    <= sq_q + {{(SQ_W-82){1'b0}}, prod_q[53:0], 28'd0};
						4'd14: sq_q    <= sq_q + {prod_q[51:0], 54'd0};
						default: ;
					endcase
					if (st_q == ST_LAST) begin
						phase_q <= S_DEC;
					end
					st_q <= st_q + 4'd1;
				end
				S_DEC: begin
					// Fraction clamped at zero, at one, or interior
					if (dot_q[DSQ_W-1] || dot_q == '0) begin
						dsq <= da_q;
						done <= 1'b1;
						phase_q <= S_IDLE;
					end else if (dot_q >= len_q) begin
						dsq <= db_q;
						done <= 1'b1;
						phase_q <= S_IDLE;
					end else begin
						rem_q <= sq_q[SQ_W-1:QW];
						lo_q  <= sq_q[QW-1:0];
						cnt_q <= '0;
						phase_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (r2 >= len_q) begin
						rem_q <= r2_sub[QW-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= r2[QW-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					lo_q  <= {lo_q[QW-2:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						dsq <= {1'b0, quo_q[QW-2:0], (r2 >= len_q)};
						done <= 1'b1;
						phase_q <= S_IDLE;
					end
				end
				default: phase_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/ppd_sqrt.sv
// Integer square root, one result bit per cycle.
`default_nettype none
module ppd_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ppd_pkg::DSQ_W-1:0] radicand,
	output logic                          done,
	output logic [ppd_pkg::RT_W-1:0]      root
);
	import ppd_pkg::*;

	localparam logic [4:0] LAST = 5'(RT_W - 1);

	logic busy_q;
	logic [4:0] cnt_q;
	logic [DSQ_W-1:0] v_q, res_q, bit_q, trial;

	assign trial = res_q + bit_q;
	assign root = res_q[RT_W-1:0];

	// Digit-by-digit root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					v_q    <= radicand;
					res_q  <= '0;
					bit_q  <= {2'b01, {(DSQ_W-2){1'b0}}};
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### src/polyline_point_distance.sv
// Top level: polyline store, query sequencer and result register.
// Items are taken one at a time. A query on an empty or single-point path answers
// without a segment walk; otherwise it walks the n-1 segments one after another
// through a single shared multiplier and a one-bit-per-cycle divider, which runs
// only for an interior projection, then takes the root of the smallest squared
// distance at the end. A finished result sits in the output register while the
// next item is taken. The point store is not cleared after reset and needs no
// clearing pass.
`default_nettype none
module polyline_point_distance #(
	parameter int MAX_POINTS = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire ppd_pkg::ppd_in_t             in_item,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output ppd_pkg::ppd_out_t                 out_item,
	input  wire logic                         cfg_we,
	input  wire logic signed [ppd_pkg::CO_W-1:0] cfg_data
);
	import ppd_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD0, ST_LD0, ST_RDN, ST_LDN, ST_SEG, ST_ROOT, ST_PUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] nxt_q;
	logic signed [CO_W-1:0] offset_q, qx_q, qy_q;
	logic signed [PT_W-1:0] p1x_q, p1y_q, p2x_q, p2y_q;
	logic [DSQ_W-1:0] best_q;
	ppd_out_t res_q;

	logic in_acc, out_acc;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic [2*CO_W-1:0] rd_data;
	logic signed [PT_W-1:0] rx, ry;
	logic seg_start, seg_done, rt_start, rt_done;
	logic [DSQ_W-1:0] seg_dsq;
	logic [RT_W-1:0] root;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	// Stored point plus offset
	assign rx = {rd_data[2*CO_W-1], rd_data[2*CO_W-1:CO_W]} + {offset_q[CO_W-1], offset_q};
	assign ry = {rd_data[CO_W-1], rd_data[CO_W-1:0]} + {offset_q[CO_W-1], offset_q};

	assign rd_en     = (state_q == ST_RD0) || (state_q == ST_RDN);
	assign rd_addr   = (state_q == ST_RD0) ? '0 : nxt_q;
	assign seg_start = (state_q == ST_LDN);
	assign rt_start  = (state_q == ST_SEG) && seg_done &&
		!((CW'(nxt_q) + CNT_ONE) < count_q);

	ppd_mem #(.DEPTH(MAX_POINTS), .AW(AW), .W(2*CO_W)) u_mem (
		.clk     (clk),
		.wr_en   (in_acc && in_item.req_type == REQ_APPEND && count_q < CNT_MAX),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({in_item.coord_x, in_item.coord_y}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ppd_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seg_start),
		.qx     (qx_q),
		.qy     (qy_q),
		.p1x    (p1x_q),
		.p1y    (p1y_q),
		.p2x    (rx),
		.p2y    (ry),
		.done   (seg_done),
		.dsq    (seg_dsq)
	);

	ppd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand ((seg_dsq < best_q) ? seg_dsq : best_q),
		.done     (rt_done),
		.root     (root)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_data;
		end
	end

	// Request sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			nxt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// Output handshake: load a waiting result, or drop a taken one
			if (state_q == ST_PUT && (!out_valid || out_acc)) begin
				out_valid <= 1'b1;
			end else if (out_acc) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_item.req_type)
							REQ_CLEAR: count_q <= '0;
							REQ_APPEND: begin
								if (count_q < CNT_MAX) begin
									count_q <= count_q + CNT_ONE;
								end
							end
							REQ_QUERY: begin
								qx_q <= in_item.coord_x;
								qy_q <= in_item.coord_y;
								if (count_q == '0) begin
									res_q <= '{distance: '0, path_status: STAT_EMPTY};
									state_q <= ST_PUT;
								end else if (count_q == CNT_ONE) begin
									res_q <= '{distance: DIST_MAX, path_status: STAT_SINGLE};
									state_q <= ST_PUT;
								end else begin
									best_q <= '1;
									nxt_q <= AW'(1);
									state_q <= ST_RD0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD0: state_q <= ST_LD0;
				ST_LD0: begin
					p1x_q <= rx;
					p1y_q <= ry;
					state_q <= ST_RDN;
				end
				ST_RDN: state_q <= ST_LDN;
				ST_LDN: begin
					p2x_q <= rx;
					p2y_q <= ry;
					state_q <= ST_SEG;
				end
				ST_SEG: begin
					if (seg_done) begin
						if (seg_dsq < best_q) begin
							best_q <= seg_dsq;
						end
						p1x_q <= p2x_q;
						p1y_q <= p2y_q;
						if ((CW'(nxt_q) + CNT_ONE) < count_q) begin
							nxt_q <= nxt_q + AW'(1);
							state_q <= ST_RDN;
						end else begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (rt_done) begin
						res_q.path_status <= STAT_NORMAL;
						res_q.distance <= (root > RT_W'(DIST_MAX)) ? DIST_MAX : root[DS_W-1:0];
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (!out_valid || out_acc) begin
						out_item  <= res_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Fill count never passes the store depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX) else $error("point count above depth");

	// Segment walk reads only written entries
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDN) |-> (CW'(nxt_q) < count_q)) else $error("read beyond path");

	// Query on an empty path answers with empty status
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_item.req_type == REQ_QUERY && count_q == '0) |=>
		(state_q == ST_PUT && res_q.path_status == STAT_EMPTY)) else $error("empty query");

	// Root finishes only while waiting for it
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> (state_q == ST_ROOT)) else $error("stray root result");

endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for polyline_point_distance: directed table, then random paths and queries, then a full path.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import ppd_pkg::*;

	localparam int MAX_PTS    = 16;
	localparam int DRAIN_CYC  = 100;
	localparam longint LIMIT  = 3000000;
	localparam int DIR_N      = 18;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [CO_W-1:0] C_MAX = 24'sh7fffff;
	localparam logic signed [CO_W-1:0] C_MIN = -24'sh800000;

	typedef struct {
		logic [1:0] req;
		int         x;
		int         y;
		bit         typed;
		int         exp_dist;
		logic [1:0] st;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_we;
	ppd_in_t  in_item;
	ppd_out_t out_item;
	logic signed [CO_W-1:0] cfg_data;

	// predictor state
	logic signed [CO_W-1:0] path_x [MAX_PTS];
	logic signed [CO_W-1:0] path_y [MAX_PTS];
	int                     path_len;
	logic signed [CO_W-1:0] cur_offset;

	ppd_out_t dist_expected_q [$];
	int     mismatches = 0;
	int     results_seen = 0;
	int     queries_sent, appends_sent;
	bit     no_idle;
	longint cycle_count = 0;

	dir_row_t dir_rows [DIR_N] = '{
		'{REQ_QUERY, 0, 0, 1, 0, STAT_EMPTY},
		'{REQ_APPEND, 8388607, 8388607, 0, 0, STAT_NORMAL},
		'{REQ_QUERY, -8388608, -8388608, 1, 33554431, STAT_SINGLE},
		'{REQ_APPEND, -8388608, -8388608, 0, 0, STAT_NORMAL},
		'{REQ_QUERY, 0, 0, 0, 0, STAT_NORMAL},
		'{REQ_QUERY, 8388607, -8388608, 0, 0, STAT_NORMAL},
		'{REQ_QUERY, -8388608, -8388608, 1, 0, STAT_NORMAL},
		'{REQ_UNUSED, 1, 1, 0, 0, STAT_NORMAL},
		'{REQ_CLEAR, 0, 0, 0, 0, STAT_NORMAL},
		'{REQ_QUERY, 5, 5, 1, 0, STAT_EMPTY},
		'{REQ_APPEND, 256, 256, 0, 0, STAT_NORMAL},
		'{REQ_APPEND, 256, 256, 0, 0, STAT_NORMAL},   // zero-length segment
		'{REQ_QUERY, 0, 0, 0, 0, STAT_NORMAL},
		'{REQ_APPEND, 1280, 256, 0, 0, STAT_NORMAL},
		'{REQ_QUERY, 768, 1024, 1, 768, STAT_NORMAL}, // interior projection
		'{REQ_QUERY, 0, 256, 1, 256, STAT_NORMAL},    // before the start
		'{REQ_QUERY, 2000, 256, 1, 720, STAT_NORMAL}, // past the end
		'{REQ_CLEAR, 0, 0, 0, 0, STAT_NORMAL}
	};

	polyline_point_distance #(.MAX_POINTS(MAX_PTS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// squared distance from a position to one segment, Q.16
	function automatic longint unsigned seg_dist_sq(longint qx, longint qy, longint x1,
			longint y1, longint x2, longint y2);
		longint ax, ay, cx, cy, dot, len, crs, bx, by;
		logic [127:0] m;
		ax  = qx - x1;
		ay  = qy - y1;
		cx  = x2 - x1;
		cy  = y2 - y1;
		dot = ax * cx + ay * cy;
		len = cx * cx + cy * cy;
		if (dot <= 0) begin
			return ax * ax + ay * ay;
		end
		if (dot >= len) begin
			bx = qx - x2;
			by = qy - y2;
			return bx * bx + by * by;
		end
		crs = ax * cy - ay * cx;
		if (crs < 0) begin
			crs = -crs;
		end
		m = 128'(crs);
		m = (m * m) / 128'(len);
		return m[63:0];
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   -= res + bt;
				res  = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	// apply one item to the path copy; gives the expected distance for a query
	function automatic void path_update(input ppd_in_t it, output bit has,
			output ppd_out_t res);
		longint unsigned best, d;
		longint off;
		has = 1'b0;
		res = '0;
		off = longint'(cur_offset);
		case (it.req_type)
			REQ_CLEAR: path_len = 0;
			REQ_APPEND: begin
				if (path_len < MAX_PTS) begin
					path_x[path_len] = it.coord_x;
					path_y[path_len] = it.coord_y;
					path_len++;
				end
			end
			REQ_QUERY: begin
				has = 1'b1;
				if (path_len == 0) begin
					res = '{distance: '0, path_status: STAT_EMPTY};
				end else if (path_len == 1) begin
					res = '{distance: DIST_MAX, path_status: STAT_SINGLE};
				end else begin
					best = '1;
					for (int i = 0; i + 1 < path_len; i++) begin
						d = seg_dist_sq(longint'(it.coord_x), longint'(it.coord_y),
							longint'(path_x[i]) + off, longint'(path_y[i]) + off,
							longint'(path_x[i+1]) + off, longint'(path_y[i+1]) + off);
						if (d < best) best = d;
					end
					d = int_root(best);
					res.distance    = d > longint'(DIST_MAX) ? DIST_MAX : d[DS_W-1:0];
					res.path_status = STAT_NORMAL;
				end
			end
			default: ;
		endcase
	endfunction

	// present one item, wait for it to be taken, then record what it should give
	task automatic send_item(input logic [1:0] req, input logic signed [CO_W-1:0] x,
			input logic signed [CO_W-1:0] y, input bit typed, input ppd_out_t typed_res);
		int gap;
		bit has;
		ppd_out_t res;
		ppd_in_t it;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		it  = '{req_type: req, coord_x: x, coord_y: y};
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		path_update(it, has, res);
		if (req == REQ_QUERY) queries_sent++;
		if (req == REQ_APPEND) appends_sent++;
		if (typed) res = typed_res;
		if (has) dist_expected_q = {dist_expected_q, res};
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (dist_expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_offset(input logic signed [CO_W-1:0] v);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_offset  = v;
	endtask

	function automatic logic signed [CO_W-1:0] pick_coord();
		case ($urandom_range(0, 6))
			0:       return C_MAX;
			1:       return C_MIN;
			2:       return CO_W'($urandom);
			default: return CO_W'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	// random paths: mostly a clear, a few points and several queries
	task automatic random_paths(input int n_items);
		int sent, npts, nq;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(REQ_UNUSED, pick_coord(), pick_coord(), 0, '0);
			end
			if ($urandom_range(0, 7) != 0) begin
				send_item(REQ_CLEAR, pick_coord(), pick_coord(), 0, '0);
				sent++;
			end
			npts = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
			for (int i = 0; i < npts; i++) begin
				send_item(REQ_APPEND, pick_coord(), pick_coord(), 0, '0);
				sent++;
			end
			nq = $urandom_range(1, 4);
			for (int i = 0; i < nq; i++) begin
				// let everything drain now and then before the next query
				if ($urandom_range(0, 9) == 0) wait_idle();
				send_item(REQ_QUERY, pick_coord(), pick_coord(), 0, '0);
				sent++;
			end
		end
	endtask

	// output stall: a drawn number of stalled cycles ahead of each result
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// result checker
	always @(posedge clk) begin
		ppd_out_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (dist_expected_q.size() == 0) begin
				$display("%0t: unexpected result distance=%0d status=%0d", $time,
					out_item.distance, out_item.path_status);
				mismatches++;
			end else begin
				exp_res = dist_expected_q.pop_front();
				if (out_item.distance !== exp_res.distance) begin
					$display("%0t: distance expected %0d actual %0d", $time,
						exp_res.distance, out_item.distance);
					mismatches++;
				end
				if (out_item.path_status !== exp_res.path_status) begin
					$display("%0t: path_status expected %0d actual %0d", $time,
						exp_res.path_status, out_item.path_status);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				dist_expected_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		ppd_out_t tr;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_item      = '0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		cur_offset   = '0;
		path_len     = 0;
		queries_sent = 0;
		appends_sent = 0;
		no_idle      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at zero offset
		write_offset('0);
		foreach (dir_rows[i]) begin
			tr.distance    = DS_W'(dir_rows[i].exp_dist);
			tr.path_status = dir_rows[i].st;
			send_item(dir_rows[i].req, CO_W'(dir_rows[i].x), CO_W'(dir_rows[i].y),
				dir_rows[i].typed, tr);
		end
		random_paths(12);

		// offset extremes and a random offset, one phase without idling
		write_offset(C_MAX);
		no_idle = 1'b1;
		random_paths(12);
		no_idle = 1'b0;
		write_offset(C_MIN);
		random_paths(12);
		write_offset(CO_W'($urandom));
		random_paths(12);

		// full path: the last append is dropped
		write_offset(24'sd128);
		send_item(REQ_CLEAR, '0, '0, 0, '0);
		for (int i = 0; i <= MAX_PTS; i++) begin
			send_item(REQ_APPEND, CO_W'(i * 300), CO_W'($urandom_range(0, 4000)), 0, '0);
		end
		for (int i = 0; i < 3; i++) begin
			send_item(REQ_QUERY, pick_coord(), pick_coord(), 0, '0);
		end

		wait_idle();
		$display("Ran %0d queries and %0d appends over five offsets; %0d results checked.",
			queries_sent, appends_sent, results_seen);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
